/* rtl/tile_map_text_console_macros.svh */
// assertion macros shared by the console rtl
// no dependencies
`ifndef TILE_MAP_TEXT_CONSOLE_MACROS_SVH
`define TILE_MAP_TEXT_CONSOLE_MACROS_SVH
// implication checked every clock outside reset
`define TMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define TMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/tmc_pkg.sv */
// constants and types for the tile map text console
// no dependencies
package tmc_pkg;
    localparam logic [7:0] KEY_ESC  = 8'd27;
    localparam logic [7:0] KEY_NL   = 8'd10;
    localparam logic [7:0] KEY_SEMI = 8'h3B;
    localparam logic [7:0] KEY_0    = 8'h30;
    localparam logic [7:0] KEY_9    = 8'h39;
    localparam logic [7:0] CMD_X    = 8'h58;
    localparam logic [7:0] CMD_Y    = 8'h59;
    localparam logic [7:0] CMD_P    = 8'h50;
    localparam logic [7:0] CMD_C    = 8'h43;
    localparam logic [7:0] CMD_W    = 8'h57;
    localparam logic [7:0] CMD_E    = 8'h45;
    localparam logic [7:0] CMD_M    = 8'h4D;
    localparam logic [7:0] CMD_A    = 8'h41;
    localparam logic [7:0] BLANK    = 8'h20;
    localparam int unsigned DEC_BASE = 10;
    localparam logic [15:0] ARG_MAX = 16'hFFFF;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_byte;
        logic        read_map;
        logic [11:0] read_index;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [7:0]  cursor_x;
        logic [7:0]  cursor_y;
        logic        in_escape;
    } t_rsp;
endpackage

/* rtl/tmc_stream_if.sv */
// valid/ready channel carrying one payload word
// payload type is set by the user
interface tmc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/tile_map_text_console.sv */
// tile map text console top level: escape parser, cursor and scroll sequencer
// uses tmc_pkg, tmc_stream_if and tile_map_text_console_macros.svh
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------
//  i_req    | in  | req_type, char_byte, read_map, read_index
//  o_rsp    | out | read_data, cursor_x, cursor_y, in_escape
//
// a plain byte passes accept, decode, tile write and result register
// a read or an escape byte passes accept, decode or memory read, result register
// scroll reads then writes each copied window tile, then blanks each bottom-row
// tile; clear writes each window tile; both hold off the input
// after reset a clearing pass writes zero to all 2*MAP_W*MAP_H tiles, one a cycle,
// before the first word is taken
// the result sits in an output register; a stalled result holds the sequencer
`include "tile_map_text_console_macros.svh"
module tile_map_text_console #(
    parameter int MAP_W     = 64,
    parameter int MAP_H     = 64,
    parameter int ARG_COUNT = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tmc_stream_if.sink   i_req,
    tmc_stream_if.source o_rsp
);
    localparam int CELLS = MAP_W * MAP_H;
    localparam int AW    = $clog2(2 * CELLS);
    localparam int PW    = $clog2(ARG_COUNT);

    // sequencer states
    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_EXEC = 4'd2,
        S_READ = 4'd3, S_SRD = 4'd4, S_SWR = 4'd5, S_BLANK = 4'd6,
        S_CLR = 4'd7, S_CHAR = 4'd8, S_OUT = 4'd9;

    logic [31:0] r_mem [2 * CELLS];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0] mem_wd;

    logic [3:0]  r_state, n_state;
    logic [AW:0] r_init, n_init;
    tmc_pkg::t_req r_req, n_req;
    logic [7:0]  r_col, n_col, r_row, n_row;
    logic [7:0]  r_wl, n_wl, r_wt, n_wt, r_ww, n_ww, r_wh, n_wh;
    logic        r_esc, n_esc, r_mapb, n_mapb;
    logic [15:0] r_args [ARG_COUNT];
    logic [15:0] n_args [ARG_COUNT];
    logic        r_pnone, n_pnone;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [15:0] r_attr, n_attr;
    // walk position (long-ish to hold sums past 255)
    logic [9:0]  r_wx, n_wx, r_wy, n_wy;
    logic        r_sval, n_sval;
    logic [7:0]  r_ch, n_ch;
    logic        r_ovalid, n_ovalid;
    tmc_pkg::t_rsp r_rsp, n_rsp;

    // window edges as wide sums
    logic [9:0] right, bottom_ex;
    assign right     = {2'b0, r_wl} + {2'b0, r_ww};
    assign bottom_ex = {2'b0, r_wt} + {2'b0, r_wh};

    function automatic logic [7:0] sat8(input logic [16:0] v);
        return (v > 17'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic in_map(input logic [9:0] x, input logic [9:0] y);
        return (x < 10'(MAP_W)) && (y < 10'(MAP_H));
    endfunction

    function automatic logic [AW-1:0] addr(input logic mb, input logic [9:0] x,
                                           input logic [9:0] y);
        logic [AW:0] a;
        a = (AW+1)'(y) * (AW+1)'(MAP_W) + (AW+1)'(x) + (mb ? (AW+1)'(CELLS) : '0);
        return a[AW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    logic [7:0]  dig;
    logic [19:0] prod;
    logic [16:0] a0w, a1w;
    assign a0w = {1'b0, r_args[0]};
    assign a1w = {1'b0, r_args[1]};

    always_comb begin
        n_state = r_state; n_init = r_init; n_req = r_req;
        n_col = r_col; n_row = r_row; n_wl = r_wl; n_wt = r_wt; n_ww = r_ww;
        n_wh = r_wh; n_esc = r_esc; n_mapb = r_mapb; n_args = r_args;
        n_pnone = r_pnone; n_ptr = r_ptr; n_attr = r_attr; n_wx = r_wx;
        n_wy = r_wy; n_sval = r_sval; n_ch = r_ch; n_ovalid = r_ovalid;
        n_rsp = r_rsp;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
        dig = r_req.char_byte - tmc_pkg::KEY_0;
        prod = 20'(r_args[r_ptr]) * 20'(tmc_pkg::DEC_BASE) + 20'(dig);
        if (o_rsp.ready) n_ovalid = 1'b0;
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1; mem_wa = r_init[AW-1:0];
                n_init = r_init + 1'b1;
                if (r_init == (AW+1)'(2 * CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.data;
                    n_state = i_req.data.req_type ? S_READ : S_EXEC;
                    mem_ra = i_req.data.read_map ? AW'(i_req.data.read_index)
                        + AW'(CELLS) : AW'(i_req.data.read_index);
                end
            end
            S_READ: begin
                n_rsp.read_data = (32'(r_req.read_index) < 32'(CELLS)) ? r_rdata : '0;
                n_state = S_OUT;
            end
            S_EXEC: begin
                n_rsp.read_data = '0;
                n_ch = r_req.char_byte;
                n_state = S_OUT;
                if (!r_esc) begin
                    if (r_req.char_byte == tmc_pkg::KEY_ESC) begin
                        n_esc = 1'b1; n_pnone = 1'b1; n_ptr = '0;
                        for (int i = 0; i < ARG_COUNT; i++) n_args[i] = '0;
                    end else n_state = S_CHAR;
                end else if (r_req.char_byte >= tmc_pkg::KEY_0 &&
                             r_req.char_byte <= tmc_pkg::KEY_9) begin
                    n_pnone = 1'b0;
                    n_args[r_ptr] = (prod > 20'(tmc_pkg::ARG_MAX)) ? tmc_pkg::ARG_MAX
                        : prod[15:0];
                end else if (r_req.char_byte == tmc_pkg::KEY_SEMI) begin
                    if (r_pnone) n_pnone = 1'b0;
                    else if (r_ptr != PW'(ARG_COUNT - 1)) n_ptr = r_ptr + 1'b1;
                end else begin
                    n_esc = 1'b0;
                    case (r_req.char_byte)
                        tmc_pkg::CMD_X: n_col = sat8(a0w + 17'(r_wl));
                        tmc_pkg::CMD_Y: n_row = sat8(a0w + 17'(r_wt));
                        tmc_pkg::CMD_P: begin
                            n_col = sat8(a0w + 17'(r_wl));
                            n_row = sat8(a1w + 17'(r_wt));
                        end
                        tmc_pkg::CMD_C: begin
                            n_wx = {2'b0, r_wl}; n_wy = {2'b0, r_wt};
                            n_col = r_wl; n_row = r_wt;
                            if (r_ww != '0 && r_wh != '0) n_state = S_CLR;
                        end
                        tmc_pkg::CMD_W: begin
                            n_wl = sat8(a0w); n_wt = sat8(a1w);
                        end
                        tmc_pkg::CMD_E: begin
                            n_ww = sat8(a0w); n_wh = sat8(a1w);
                        end
                        tmc_pkg::CMD_M: n_mapb = (r_args[0] != '0);
                        tmc_pkg::CMD_A: n_attr = r_args[0];
                        default: n_state = S_CHAR;
                    endcase
                end
            end
            S_CLR: begin
                mem_we = in_map(r_wx, r_wy);
                mem_wa = addr(r_mapb, r_wx, r_wy);
                mem_wd = 32'(tmc_pkg::BLANK) + 32'(r_attr);
                if (r_wx + 10'd1 >= right) begin
                    n_wx = {2'b0, r_wl}; n_wy = r_wy + 10'd1;
                    if (r_wy + 10'd1 >= bottom_ex) n_state = S_OUT;
                end else n_wx = r_wx + 10'd1;
            end
            S_CHAR: begin
                // wrap or newline
                if ({2'b0, r_col} >= right || r_ch == tmc_pkg::KEY_NL) begin
                    n_col = r_wl;
                    if ({2'b0, r_row} + 10'd1 >= bottom_ex) begin
                        n_wx = {2'b0, r_wl}; n_wy = {2'b0, r_wt};
                        n_row = sat8(17'(r_row));
                        if ({2'b0, r_wt} + 10'd1 < bottom_ex && r_ww != '0)
                            n_state = S_SRD;
                        else if (r_ww != '0) begin
                            n_wy = bottom_ex - 10'd1; n_state = S_BLANK;
                        end else if (r_ch == tmc_pkg::KEY_NL) n_state = S_OUT;
                        // zero-width window: nothing to scroll, char placed on the current row
                    end else n_row = sat8(17'(r_row) + 17'd1);
                    if (n_state == S_CHAR) n_state = (r_ch == tmc_pkg::KEY_NL) ?
                        S_OUT : S_CHAR;
                    // after a wrap with no scroll, place the char at the left column here
                    if (r_ch == tmc_pkg::KEY_NL && n_state == S_CHAR) n_state = S_OUT;
                    if (r_ch != tmc_pkg::KEY_NL && n_state == S_CHAR) begin
                        mem_we = in_map(10'(r_wl), 10'(n_row));
                        mem_wa = addr(r_mapb, 10'(r_wl), 10'(n_row));
                        mem_wd = 32'(r_ch) + 32'(r_attr);
                        n_col = sat8(17'(r_wl) + 17'd1);
                        n_state = S_OUT;
                    end
                end else begin
                    mem_we = in_map(10'(r_col), 10'(r_row));
                    mem_wa = addr(r_mapb, 10'(r_col), 10'(r_row));
                    mem_wd = 32'(r_ch) + 32'(r_attr);
                    n_col = sat8(17'(r_col) + 17'd1);
                    n_state = S_OUT;
                end
            end
            S_SRD: begin
                // fetch the tile one row below
                n_sval = in_map(r_wx, r_wy + 10'd1);
                mem_ra = addr(r_mapb, r_wx, r_wy + 10'd1);
                n_state = S_SWR;
            end
            S_SWR: begin
                mem_we = in_map(r_wx, r_wy);
                mem_wa = addr(r_mapb, r_wx, r_wy);
                mem_wd = r_sval ? r_rdata : '0;
                n_state = S_SRD;
                if (r_wx + 10'd1 >= right) begin
                    n_wx = {2'b0, r_wl}; n_wy = r_wy + 10'd1;
                    if (r_wy + 10'd2 >= bottom_ex) n_state = S_BLANK;
                end else n_wx = r_wx + 10'd1;
            end
            S_BLANK: begin
                mem_we = in_map(r_wx, r_wy);
                mem_wa = addr(r_mapb, r_wx, r_wy);
                mem_wd = 32'(tmc_pkg::BLANK);
                if (r_wx + 10'd1 >= right) begin
                    // scroll done; place pending character at the left column
                    n_state = (r_ch == tmc_pkg::KEY_NL) ? S_OUT : S_CHAR;
                    n_col = r_wl;
                    if (r_ch != tmc_pkg::KEY_NL) n_col = r_wl;
                end else n_wx = r_wx + 10'd1;
            end
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_rsp.cursor_x = r_col; n_rsp.cursor_y = r_row;
                    n_rsp.in_escape = r_esc;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE) && (!r_ovalid || o_rsp.ready);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_init <= '0; r_col <= '0; r_row <= '0;
            r_wl <= '0; r_wt <= '0; r_ww <= 8'd30; r_wh <= 8'd20;
            r_esc <= 1'b0; r_mapb <= 1'b0; r_pnone <= 1'b1; r_ptr <= '0;
            r_attr <= '0; r_ovalid <= 1'b0;
            for (int i = 0; i < ARG_COUNT; i++) r_args[i] <= '0;
        end else begin
            r_state <= (r_state == S_IDLE && !i_req.ready) ? S_IDLE : n_state;
            r_init <= n_init; r_col <= n_col; r_row <= n_row;
            r_wl <= n_wl; r_wt <= n_wt; r_ww <= n_ww; r_wh <= n_wh;
            r_esc <= n_esc; r_mapb <= n_mapb; r_pnone <= n_pnone; r_ptr <= n_ptr;
            r_attr <= n_attr; r_ovalid <= n_ovalid; r_args <= n_args;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_wx <= n_wx; r_wy <= n_wy; r_sval <= n_sval;
        r_ch <= n_ch; r_rsp <= n_rsp;
    end

    `TMC_ASSERT_IMP(a_no_accept_init, i_clk, i_rst_n, r_state == S_INIT, !i_req.ready)
    `TMC_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n,
        i_req.valid && i_req.ready, r_state == S_READ || r_state == S_EXEC)
    `TMC_ASSERT_IMP(a_ptr_range, i_clk, i_rst_n, 1'b1, r_ptr <= PW'(ARG_COUNT - 1))
    `TMC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready,
        o_rsp.valid && $stable(o_rsp.data))
endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// testbench for tile_map_text_console: directed table, then random text, escapes and reads
// depends on tmc_pkg, tmc_stream_if and the console rtl
module tb;
    localparam int MAP_W = 64;
    localparam int MAP_H = 64;
    localparam int ARG_COUNT = 3;
    localparam int MAP_CELLS = MAP_W * MAP_H;
    localparam int IDLE_PCT = 14;
    localparam int STALL_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        tmc_pkg::t_req req;
        bit            fixed;
        tmc_pkg::t_rsp rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tmc_stream_if #(.T(tmc_pkg::t_req)) req_ch ();
    tmc_stream_if #(.T(tmc_pkg::t_rsp)) rsp_ch ();

    tile_map_text_console #(.MAP_W(MAP_W), .MAP_H(MAP_H), .ARG_COUNT(ARG_COUNT)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // shadow console state
    logic [31:0] tiles [0:2*MAP_CELLS-1];
    int          col, row, win_l, win_t, win_w, win_h;
    bit          esc_on, map_b;
    int unsigned args [ARG_COUNT];
    int          arg_ptr;
    int unsigned attr;

    t_row          stim_q [$];
    bit            fixed_q [$];
    tmc_pkg::t_rsp fixed_rsp_q [$];
    tmc_pkg::t_rsp rsp_q [$];
    int            err_cnt;
    bit            quiet;
    bit            hold_rsp;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int sat255(longint v);
        if (v < 0) return 0;
        return (v > 255) ? 255 : int'(v);
    endfunction

    function automatic logic [31:0] get_tile(longint x, longint y);
        if (x < 0 || y < 0 || x >= MAP_W || y >= MAP_H) return '0;
        return tiles[(map_b ? MAP_CELLS : 0) + y * MAP_W + x];
    endfunction

    task automatic put_tile(longint x, longint y, logic [31:0] v);
        if (x < 0 || y < 0 || x >= MAP_W || y >= MAP_H) return;
        tiles[(map_b ? MAP_CELLS : 0) + y * MAP_W + x] = v;
    endtask

    // wrap, scroll and tile write for one printable byte
    task automatic print_byte(logic [7:0] c);
        longint right, y, bottom;
        right = longint'(win_l) + win_w;
        if (col >= right || c == tmc_pkg::KEY_NL) begin
            y = longint'(row) + 1;
            col = win_l;
            if (y >= longint'(win_t) + win_h) begin
                bottom = longint'(win_t) + win_h - 1;
                for (longint r = win_t; r < bottom; r++)
                    for (longint x = win_l; x < right; x++)
                        put_tile(x, r, get_tile(x, r + 1));
                for (longint x = win_l; x < right; x++)
                    put_tile(x, bottom, 32'(tmc_pkg::BLANK));
                y--;
            end
            row = sat255(y);
        end
        if (c != tmc_pkg::KEY_NL) begin
            put_tile(col, row, 32'(c) + attr);
            col = sat255(longint'(col) + 1);
        end
    endtask

    task automatic run_cmd(logic [7:0] c);
        longint a0, a1;
        a0 = args[0];
        a1 = args[1];
        case (c)
            tmc_pkg::CMD_X: col = sat255(a0 + win_l);
            tmc_pkg::CMD_Y: row = sat255(a0 + win_t);
            tmc_pkg::CMD_P: begin
                col = sat255(a0 + win_l);
                row = sat255(a1 + win_t);
            end
            tmc_pkg::CMD_C: begin
                for (longint y = win_t; y < longint'(win_t) + win_h; y++)
                    for (longint x = win_l; x < longint'(win_l) + win_w; x++)
                        put_tile(x, y, 32'(tmc_pkg::BLANK) + attr);
                col = win_l;
                row = win_t;
            end
            tmc_pkg::CMD_W: begin
                win_l = sat255(a0);
                win_t = sat255(a1);
            end
            tmc_pkg::CMD_E: begin
                win_w = sat255(a0);
                win_h = sat255(a1);
            end
            tmc_pkg::CMD_M: map_b = (a0 != 0);
            tmc_pkg::CMD_A: attr = 32'(a0[15:0]);
            default: print_byte(c);
        endcase
        esc_on = 1'b0;
    endtask

    task automatic console_reset();
        foreach (tiles[i]) tiles[i] = '0;
        col = 0; row = 0; win_l = 0; win_t = 0; win_w = 30; win_h = 20;
        esc_on = 1'b0; map_b = 1'b0; arg_ptr = -1; attr = 0;
        foreach (args[i]) args[i] = 0;
    endtask

    // advance the shadow console by one word and return what the block should answer
    task automatic predict_rsp(input tmc_pkg::t_req r, output tmc_pkg::t_rsp o);
        int unsigned v;
        o.read_data = '0;
        if (r.req_type) begin
            if (r.read_index < MAP_CELLS)
                o.read_data = tiles[(r.read_map ? MAP_CELLS : 0) + r.read_index];
        end else if (!esc_on) begin
            if (r.char_byte == tmc_pkg::KEY_ESC) begin
                esc_on = 1'b1;
                foreach (args[i]) args[i] = 0;
                arg_ptr = -1;
            end else begin
                print_byte(r.char_byte);
            end
        end else if (r.char_byte >= tmc_pkg::KEY_0 && r.char_byte <= tmc_pkg::KEY_9) begin
            if (arg_ptr < 0) arg_ptr = 0;
            v = args[arg_ptr] * tmc_pkg::DEC_BASE + 32'(r.char_byte - tmc_pkg::KEY_0);
            args[arg_ptr] = (v > tmc_pkg::ARG_MAX) ? 32'(tmc_pkg::ARG_MAX) : v;
        end else if (r.char_byte == tmc_pkg::KEY_SEMI) begin
            arg_ptr++;
            if (arg_ptr >= ARG_COUNT) arg_ptr = ARG_COUNT - 1;
        end else begin
            run_cmd(r.char_byte);
        end
        o.cursor_x = col[7:0];
        o.cursor_y = row[7:0];
        o.in_escape = esc_on;
    endtask

    task automatic report(string fld, logic [31:0] got, logic [31:0] want);
        err_cnt++;
        $display("mismatch %s: got %0h want %0h at %0t", fld, got, want, $realtime);
    endtask

    // stimulus table helpers
    task automatic add_byte(logic [7:0] b, bit fx = 0, tmc_pkg::t_rsp e = '0);
        t_row w;
        w.req = '{req_type: 1'b0, char_byte: b, read_map: 1'b0,
                  read_index: 12'($urandom)};
        w.fixed = fx;
        w.rsp = e;
        stim_q.push_back(w);
    endtask

    task automatic add_read(bit m, logic [11:0] idx, bit fx = 0, tmc_pkg::t_rsp e = '0);
        t_row w;
        w.req = '{req_type: 1'b1, char_byte: 8'($urandom), read_map: m, read_index: idx};
        w.fixed = fx;
        w.rsp = e;
        stim_q.push_back(w);
    endtask

    task automatic add_num(int unsigned n);
        string s;
        s.itoa(n);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // escape sequence with one or two arguments
    task automatic add_esc(logic [7:0] cmd, int unsigned a0, int unsigned a1, bit two = 1);
        add_byte(tmc_pkg::KEY_ESC);
        add_num(a0);
        if (two) begin
            add_byte(tmc_pkg::KEY_SEMI);
            add_num(a1);
        end
        add_byte(cmd);
    endtask

    task automatic build_directed();
        // after reset: empty map, cursor home
        add_read(1'b0, 12'd0, 1, '{32'd0, 8'd0, 8'd0, 1'b0});
        add_byte(tmc_pkg::CMD_A, 1, '{32'd0, 8'd1, 8'd0, 1'b0});
        add_read(1'b0, 12'd0, 1, '{32'h41, 8'd1, 8'd0, 1'b0});
        add_read(1'b1, 12'hFFF, 1, '{32'd0, 8'd1, 8'd0, 1'b0});
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(tmc_pkg::KEY_NL);
        add_byte(tmc_pkg::KEY_ESC, 1, '{32'd0, 8'd0, 8'd1, 1'b1});
        add_byte(tmc_pkg::KEY_SEMI);
        add_byte(tmc_pkg::KEY_SEMI);
        add_byte(tmc_pkg::KEY_SEMI);
        add_byte(8'h35);
        add_byte(tmc_pkg::CMD_X);
        add_esc(tmc_pkg::CMD_A, 99999, 0, 0);        // attribute saturates
        add_byte(8'h7E);
        add_read(1'b0, 12'd69);
        add_esc(tmc_pkg::CMD_W, 300, 300);           // window start saturates, writes dropped
        add_byte(8'h61);
        add_esc(tmc_pkg::CMD_W, 0, 0);
        add_esc(tmc_pkg::CMD_E, 255, 255);           // widest window, full clear
        add_esc(tmc_pkg::CMD_C, 0, 0, 0);
        add_esc(tmc_pkg::CMD_P, 300, 300);           // cursor saturates
        add_esc(tmc_pkg::CMD_E, 3, 2);
        add_esc(tmc_pkg::CMD_A, 0, 0, 0);
        add_esc(tmc_pkg::CMD_M, 1, 0, 0);
        add_esc(tmc_pkg::CMD_C, 0, 0, 0);
        for (int i = 0; i < 8; i++) add_byte(8'(8'h30 + i));  // wrap and scroll
        add_byte(tmc_pkg::KEY_ESC);
        add_byte(tmc_pkg::KEY_ESC);                  // esc inside a sequence prints
        add_byte(tmc_pkg::KEY_ESC);
        add_byte(8'h3F);                             // unknown command prints
        add_esc(tmc_pkg::CMD_E, 4, 0);               // zero height scroll
        add_byte(tmc_pkg::KEY_NL);
        add_esc(tmc_pkg::CMD_E, 0, 3);               // zero width wrap
        add_byte(8'h62);
        add_byte(8'h63);
        add_esc(tmc_pkg::CMD_Y, 2, 0, 0);
        add_esc(tmc_pkg::CMD_E, 30, 20);
        add_esc(tmc_pkg::CMD_M, 0, 0, 0);
    endtask

    task automatic build_random(int target);
        logic [7:0] cmds [8];
        int k;
        cmds = '{tmc_pkg::CMD_X, tmc_pkg::CMD_Y, tmc_pkg::CMD_P, tmc_pkg::CMD_C,
                 tmc_pkg::CMD_W, tmc_pkg::CMD_E, tmc_pkg::CMD_M, tmc_pkg::CMD_A};
        while (stim_q.size() < target) begin
            k = $urandom_range(0, 99);
            if (k < 45) add_byte(8'($urandom_range(0, 255)));
            else if (k < 52) add_byte(tmc_pkg::KEY_NL);
            else if (k < 67) add_read(1'($urandom_range(0, 1)), 12'($urandom));
            else if (k < 72) begin
                // broken or noisy sequence
                add_byte(tmc_pkg::KEY_ESC);
                repeat ($urandom_range(0, 4))
                    add_byte($urandom_range(0, 1) ? tmc_pkg::KEY_SEMI
                                                  : 8'($urandom_range(48, 57)));
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                case (cmds[$urandom_range(0, 7)])
                    tmc_pkg::CMD_W: add_esc(tmc_pkg::CMD_W, $urandom_range(0, 70),
                                            $urandom_range(0, 70));
                    tmc_pkg::CMD_E: add_esc(tmc_pkg::CMD_E, $urandom_range(0, 12),
                                            $urandom_range(0, 8));
                    tmc_pkg::CMD_X: add_esc(tmc_pkg::CMD_X, $urandom_range(0, 80), 0, 0);
                    tmc_pkg::CMD_Y: add_esc(tmc_pkg::CMD_Y, $urandom_range(0, 80), 0, 0);
                    tmc_pkg::CMD_P: add_esc(tmc_pkg::CMD_P, $urandom_range(0, 300),
                                            $urandom_range(0, 20));
                    tmc_pkg::CMD_C: add_esc(tmc_pkg::CMD_C, 0, 0, 0);
                    tmc_pkg::CMD_M: add_esc(tmc_pkg::CMD_M, $urandom_range(0, 2), 0, 0);
                    default: add_esc(tmc_pkg::CMD_A, $urandom_range(0, 65535), 0, 0);
                endcase
            end
        end
    endtask

    // response sink with random stalls and one long hold-off
    initial begin
        int hold;
        bit held;
        rsp_ch.ready <= 1'b0;
        hold = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rsp && !held) begin
                hold = 400;
                held = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // scoreboard: outputs first, then the accepted input word
    always @(posedge i_clk) begin
        tmc_pkg::t_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_q.size() == 0) begin
                report("unexpected word", 32'(rsp_ch.data.cursor_x), 32'd0);
            end else begin
                e = rsp_q.pop_front();
                if (rsp_ch.data.read_data !== e.read_data)
                    report("read_data", rsp_ch.data.read_data, e.read_data);
                if (rsp_ch.data.cursor_x !== e.cursor_x)
                    report("cursor_x", 32'(rsp_ch.data.cursor_x), 32'(e.cursor_x));
                if (rsp_ch.data.cursor_y !== e.cursor_y)
                    report("cursor_y", 32'(rsp_ch.data.cursor_y), 32'(e.cursor_y));
                if (rsp_ch.data.in_escape !== e.in_escape)
                    report("in_escape", 32'(rsp_ch.data.in_escape), 32'(e.in_escape));
            end
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            predict_rsp(req_ch.data, e);
            if (fixed_q.pop_front()) e = fixed_rsp_q.pop_front();
            else void'(fixed_rsp_q.pop_front());
            rsp_q.push_back(e);
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin
        int idle_cyc;
        idle_cyc = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cyc = 0;
            else
                idle_cyc++;
            if (idle_cyc >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        t_row w;
        int n;
        err_cnt = 0;
        quiet = 1'b0;
        hold_rsp = 1'b0;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        console_reset();
        build_directed();
        build_random(500);
        foreach (stim_q[i]) begin
            fixed_q.push_back(stim_q[i].fixed);
            fixed_rsp_q.push_back(stim_q[i].rsp);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        n = 0;
        while (stim_q.size() > 0) begin
            w = stim_q.pop_front();
            // stretch with no idling on either side
            quiet = (n >= 150 && n < 260);
            if (n == 300) hold_rsp = 1'b1;   // sink backs up while we keep offering
            if (n == 420) begin
                // pause until the block has drained
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (rsp_q.size() > 0) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            req_ch.valid <= 1'b1;
            req_ch.data <= w.req;
            @(posedge i_clk);
            while (!req_ch.ready) @(posedge i_clk);
            n++;
        end
        req_ch.valid <= 1'b0;
        quiet = 1'b0;

        @(posedge i_clk);
        while (rsp_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
